// File: hw/rtl/u8dec_pkg.sv
// Package for the UTF-8 byte stream decoder: result status codes, widths,
// the byte order mark value and the decoder state record.
// Depends on nothing; every other file of the decoder imports it.
`default_nettype none

package u8dec_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;

	// Code point of the byte order mark.
	localparam logic [CP_W-1:0] MARK_VALUE = CP_W'(21'h00FEFF);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PENDING = 2'd0,
		ST_EMIT    = 2'd1,
		ST_MARK    = 2'd2,
		ST_ERROR   = 2'd3
	} status_t;

	// Decoder state carried from one byte to the next.
	typedef struct packed {
		logic [1:0]      bytes_remaining;
		logic [CP_W-1:0] partial_value;
		logic            mark_seen;
		logic            anything_emitted;
	} dec_state_t;

	// One result item.
	typedef struct packed {
		status_t         status;
		logic [CP_W-1:0] code_point;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/u8dec_byte_if.sv
// Valid/ready channel that carries one raw byte of the UTF-8 stream per item.
// Depends on u8dec_pkg for the byte width.
`default_nettype none

interface u8dec_byte_if
	import u8dec_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/u8dec_result_if.sv
// Valid/ready channel that carries one decoder result item: status and code point.
// Depends on u8dec_pkg for the status type and code point width.
`default_nettype none

interface u8dec_result_if
	import u8dec_pkg::*;
();
	logic            valid;
	logic            ready;
	status_t         status;
	logic [CP_W-1:0] code_point;

	modport source (output valid, output status, output code_point, input ready);
	modport sink (input valid, input status, input code_point, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/u8dec_step.sv
// Combinational decode step: from the current state and one byte, works out
// the next state and the result item. Depends on u8dec_pkg.
`default_nettype none

module u8dec_step
	import u8dec_pkg::*;
(
	input  wire dec_state_t        cur,
	input  wire logic [BYTE_W-1:0] in_byte,
	output dec_state_t             nxt,
	output result_t                res
);

	logic [CP_W-1:0] shifted;
	logic            is_cont;

	// Continuation bytes look like 10xxxxxx and bring six payload bits.
	assign is_cont = (in_byte[7:6] == 2'b10);
	assign shifted = {cur.partial_value[CP_W-7:0], in_byte[5:0]};

	always_comb begin
		nxt            = cur;
		res.status     = ST_PENDING;
		res.code_point = '0;
		if (cur.bytes_remaining == 2'd0) begin
			// No sequence open: classify the lead byte.
			priority casez (in_byte)
				8'b0???????: begin
					nxt.anything_emitted = 1'b1;
					res.status           = ST_EMIT;
					res.code_point       = CP_W'(in_byte[6:0]);
				end
				8'b110?????: begin
					nxt.bytes_remaining = 2'd1;
					nxt.partial_value   = CP_W'(in_byte[4:0]);
				end
				8'b1110????: begin
					nxt.bytes_remaining = 2'd2;
					nxt.partial_value   = CP_W'(in_byte[3:0]);
				end
				8'b11110???: begin
					nxt.bytes_remaining = 2'd3;
					nxt.partial_value   = CP_W'(in_byte[2:0]);
				end
				default: begin
					// Stray continuation or invalid lead byte.
					nxt.partial_value = '0;
					res.status        = ST_ERROR;
				end
			endcase
		end else if (!is_cont) begin
			// Missing continuation: drop the sequence and the byte.
			nxt.bytes_remaining = 2'd0;
			nxt.partial_value   = '0;
			res.status          = ST_ERROR;
		end else if (cur.bytes_remaining != 2'd1) begin
			nxt.bytes_remaining = cur.bytes_remaining - 2'd1;
			nxt.partial_value   = shifted;
		end else begin
			// Last byte of the sequence: emit, or handle the byte order mark.
			nxt.bytes_remaining = 2'd0;
			nxt.partial_value   = '0;
			if (shifted == MARK_VALUE) begin
				if (cur.anything_emitted || cur.mark_seen) begin
					res.status = ST_ERROR;
				end else begin
					nxt.mark_seen = 1'b1;
					res.status    = ST_MARK;
				end
			end else begin
				nxt.anything_emitted = 1'b1;
				res.status           = ST_EMIT;
				res.code_point       = shifted;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/utf8_byte_stream_decoder_core.sv
// UTF-8 byte stream decoder, top level. Depends on u8dec_pkg, u8dec_byte_if,
// u8dec_result_if and u8dec_step.
// The result of a byte is registered and offered in the cycle after the byte is
// accepted. Throughput: one byte per cycle while results are taken; the single
// decode step and result register take a new byte while the previous is taken.
// Reset clears the decoder state, both flags and the result valid flag.
`default_nettype none

module utf8_byte_stream_decoder_core
	import u8dec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	u8dec_byte_if.sink     bytes,
	u8dec_result_if.source results
);

	dec_state_t state_q;
	dec_state_t state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       res_valid_q;
	logic       take;

	// A byte is taken whenever the result register is empty or being drained.
	assign bytes.ready = !res_valid_q || results.ready;
	assign take        = bytes.valid && bytes.ready;

	u8dec_step u_step (
		.cur     (state_q),
		.in_byte (bytes.in_byte),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// Decoder state and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q <= state_nxt;
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_nxt;
		end
	end

	assign results.valid      = res_valid_q;
	assign results.status     = res_q.status;
	assign results.code_point = res_q.code_point;

endmodule

`default_nettype wire
